/* rtl/ovsd_pkg.sv */
// ----------------------------------------------------------------------------
// ovsd_pkg
// Shared widths, constants and types of the overlay scale-delta calculator.
// ----------------------------------------------------------------------------
package ovsd_pkg;

    localparam int WIDTH_W    = 12;
    localparam int SHRINK_W   = 28;
    localparam int ZOOM_W     = 18;

    // Both aligned widths are multiples of four, so the quotient is formed
    // from the widths with their low two bits dropped.
    localparam int DIV_W      = WIDTH_W - 2;
    localparam int FRAC_W     = 16;
    localparam int NUM_W      = DIV_W + FRAC_W;
    localparam int DIV_BITS   = 2;
    localparam int DIV_STAGES = NUM_W / DIV_BITS;

    // Only bits 17..16 of step * destination are examined.
    localparam int CHK_W      = FRAC_W + 2;

    localparam logic [WIDTH_W-1:0]  ALIGN_MASK  = 12'hffc;
    localparam logic [SHRINK_W-1:0] UNITY_STEP  = 28'h001_0000;
    localparam logic [SHRINK_W-1:0] SHRINK_MASK = 28'hfff_fff0;
    localparam logic [SHRINK_W-1:0] ZOOM_MASK   = 28'h001_fff0;
    localparam logic [SHRINK_W-1:0] ROUND_ADD   = 28'h000_000f;
    localparam logic [SHRINK_W-1:0] STEP_INC    = 28'h000_0010;
    localparam logic [ZOOM_W-1:0]   ZOOM_MAX    = 18'h2_0000;

    // Per-request information that travels beside the quotient.
    typedef struct packed {
        logic [WIDTH_W-1:0] src_aligned;
        logic [WIDTH_W-1:0] dst_aligned;
        logic               shrinking;
        logic               div_err;
    } t_side;

endpackage

/* rtl/ovsd_div.sv */
// ----------------------------------------------------------------------------
// ovsd_div
// Pipelined restoring divider, DIV_BITS quotient bits per register stage.
// ----------------------------------------------------------------------------
module ovsd_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_vld,
    input  logic [ovsd_pkg::NUM_W-1:0] i_num,
    input  logic [ovsd_pkg::DIV_W-1:0] i_dvs,
    input  ovsd_pkg::t_side            i_side,
    output logic                       o_vld,
    output logic [ovsd_pkg::NUM_W-1:0] o_quo,
    output ovsd_pkg::t_side            o_side
);
    import ovsd_pkg::*;

    logic             r_vld  [DIV_STAGES];
    logic [DIV_W-1:0] r_rem  [DIV_STAGES];
    logic [NUM_W-1:0] r_nq   [DIV_STAGES];
    logic [DIV_W-1:0] r_dvs  [DIV_STAGES];
    t_side            r_side [DIV_STAGES];

    for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
        logic             vld_in;
        logic [DIV_W-1:0] rem_in;
        logic [NUM_W-1:0] nq_in;
        logic [DIV_W-1:0] dvs_in;
        t_side            side_in;
        logic [DIV_W-1:0] n_rem;
        logic [NUM_W-1:0] n_nq;

        if (s == 0) begin : g_first
            assign vld_in  = i_vld;
            assign rem_in  = '0;
            assign nq_in   = i_num;
            assign dvs_in  = i_dvs;
            assign side_in = i_side;
        end else begin : g_next
            assign vld_in  = r_vld[s-1];
            assign rem_in  = r_rem[s-1];
            assign nq_in   = r_nq[s-1];
            assign dvs_in  = r_dvs[s-1];
            assign side_in = r_side[s-1];
        end

        // The numerator shifts out at the top while quotient bits enter at
        // the bottom of the same register.
        always_comb begin : stage_logic
            logic [DIV_W:0] trial;
            n_rem = rem_in;
            n_nq  = nq_in;
            trial = '0;
            for (int b = 0; b < DIV_BITS; b++) begin
                trial = {n_rem, n_nq[NUM_W-1]};
                n_nq  = {n_nq[NUM_W-2:0], 1'b0};
                if (trial >= {1'b0, dvs_in}) begin
                    n_rem   = DIV_W'(trial - {1'b0, dvs_in});
                    n_nq[0] = 1'b1;
                end else begin
                    n_rem = trial[DIV_W-1:0];
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else begin
                r_vld[s] <= vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            r_rem[s]  <= n_rem;
            r_nq[s]   <= n_nq;
            r_dvs[s]  <= dvs_in;
            r_side[s] <= side_in;
        end
    end

    assign o_vld  = r_vld[DIV_STAGES-1];
    assign o_quo  = r_nq[DIV_STAGES-1];
    assign o_side = r_side[DIV_STAGES-1];

endmodule

/* rtl/overlay_scale_delta_calc.sv */
// ----------------------------------------------------------------------------
// overlay_scale_delta_calc
// Horizontal shrink and zoom step calculator for an overlay scaler.
// ----------------------------------------------------------------------------
// A request is a source width and a displayed width, taken at a rising edge
// where start is high and busy is low. busy stays low at all times, so one
// request can be accepted every clock cycle.
// Each request yields one result: both widths with their low two bits
// cleared, the shrink step in 12.16 and the zoom step in 2.16 fixed point,
// and a flag for a zero aligned destination (both steps are then unity).
// The result is on the o_ ports for exactly one cycle, marked by o_done.
// Results leave in request order.
// The pipeline is 13 divider stages that resolve two
// quotient bits each, followed by a rounding stage, a check-product stage
// and the output register.
// The receiver cannot hold results off, so nothing in the pipeline stalls.
// A synchronous reset drops every request in flight; no result follows for
// requests accepted before reset.
// ----------------------------------------------------------------------------
module overlay_scale_delta_calc (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [ovsd_pkg::WIDTH_W-1:0]    i_source_width,
    input  logic [ovsd_pkg::WIDTH_W-1:0]    i_target_width,
    output logic                            o_done,
    output logic [ovsd_pkg::WIDTH_W-1:0]    o_source_width_aligned,
    output logic [ovsd_pkg::WIDTH_W-1:0]    o_target_width_aligned,
    output logic [ovsd_pkg::SHRINK_W-1:0]   o_shrink_step,
    output logic [ovsd_pkg::ZOOM_W-1:0]     o_zoom_step,
    output logic                            o_divide_error
);
    import ovsd_pkg::*;

    logic                req_acc;
    t_side               in_side;
    logic [WIDTH_W-1:0]  src_al;
    logic [WIDTH_W-1:0]  dst_al;

    logic                div_vld;
    logic [NUM_W-1:0]    div_quo;
    t_side               div_side;

    logic                r_s1_vld;
    logic [SHRINK_W-1:0] r_s1_step;
    t_side               r_s1_side;
    logic [SHRINK_W-1:0] n_s1_step;

    logic                r_s2_vld;
    logic [SHRINK_W-1:0] r_s2_step;
    logic                r_s2_chk;
    t_side               r_s2_side;
    logic [CHK_W-1:0]    n_s2_prod;

    logic [SHRINK_W-1:0] n_s3_step;
    logic [SHRINK_W-1:0] n_s3_shrink;
    logic [SHRINK_W-1:0] n_s3_zoom;

    logic                r_done;
    logic [WIDTH_W-1:0]  r_src_al;
    logic [WIDTH_W-1:0]  r_dst_al;
    logic [SHRINK_W-1:0] r_shrink;
    logic [ZOOM_W-1:0]   r_zoom;
    logic                r_err;

    assign busy    = 1'b0;
    assign req_acc = start && !busy;

    // The shrink/zoom decision uses the widths before alignment.
    assign src_al = i_source_width & ALIGN_MASK;
    assign dst_al = i_target_width & ALIGN_MASK;

    always_comb begin
        in_side.src_aligned = src_al;
        in_side.dst_aligned = dst_al;
        in_side.shrinking   = (i_source_width >= i_target_width);
        in_side.div_err     = (dst_al == '0);
    end

    ovsd_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (req_acc),
        .i_num   ({src_al[WIDTH_W-1:2], {FRAC_W{1'b0}}}),
        .i_dvs   (dst_al[WIDTH_W-1:2]),
        .i_side  (in_side),
        .o_vld   (div_vld),
        .o_quo   (div_quo),
        .o_side  (div_side)
    );

    // Round the ratio up to a multiple of 16 and apply the branch mask.
    always_comb begin
        n_s1_step = (SHRINK_W'(div_quo) + ROUND_ADD)
                    & (div_side.shrinking ? SHRINK_MASK : ZOOM_MASK);
    end

    always_ff @(posedge i_clk) begin
        r_s1_step <= n_s1_step;
        r_s1_side <= div_side;
    end

    // Only bits 17..16 of the product matter, so the low bits suffice.
    assign n_s2_prod = CHK_W'(r_s1_step[CHK_W-1:0] * CHK_W'(r_s1_side.dst_aligned));

    always_ff @(posedge i_clk) begin
        r_s2_step <= r_s1_step;
        r_s2_chk  <= |n_s2_prod[CHK_W-1:FRAC_W];
        r_s2_side <= r_s1_side;
    end

    always_comb begin
        n_s3_step   = r_s2_step + (r_s2_chk ? STEP_INC : '0);
        n_s3_shrink = UNITY_STEP;
        n_s3_zoom   = UNITY_STEP;
        if (!r_s2_side.div_err) begin
            if (r_s2_side.shrinking) begin
                n_s3_shrink = n_s3_step;
            end else begin
                n_s3_zoom = n_s3_step;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_src_al <= r_s2_side.src_aligned;
        r_dst_al <= r_s2_side.dst_aligned;
        r_shrink <= n_s3_shrink;
        r_zoom   <= n_s3_zoom[ZOOM_W-1:0];
        r_err    <= r_s2_side.div_err;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_done   <= 1'b0;
        end else begin
            r_s1_vld <= div_vld;
            r_s2_vld <= r_s1_vld;
            r_done   <= r_s2_vld;
        end
    end

    assign o_done                 = r_done;
    assign o_source_width_aligned = r_src_al;
    assign o_target_width_aligned = r_dst_al;
    assign o_shrink_step          = r_shrink;
    assign o_zoom_step            = r_zoom;
    assign o_divide_error         = r_err;

    // The error flag must agree with the aligned destination it came with.
    a_err_matches_dst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_divide_error == (o_target_width_aligned == '0)))
        else $error("divide_error does not match the aligned destination");

    a_err_unity: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_divide_error |->
            (o_shrink_step == UNITY_STEP) && (o_zoom_step == UNITY_STEP[ZOOM_W-1:0]))
        else $error("error result without unity steps");

    a_one_unity: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_shrink_step == UNITY_STEP)
                || (o_zoom_step == UNITY_STEP[ZOOM_W-1:0]))
        else $error("neither step is unity");

    a_zoom_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_zoom_step <= ZOOM_MAX))
        else $error("zoom step out of range");

endmodule
